FILE: rtl/bpvl_pkg.sv
package bpvl_pkg;

   typedef logic signed [15:0] q14_type;

   // stages inside one vector normalizer: magnitude, leading one, align, square, sum,
   // 31 root bits, numerator, 15 quotient bits, sign
   localparam int NORM_LAT = 53;

   localparam int LIGHT_X_Q16 = -200 * 65536;
   localparam int LIGHT_Y_Q16 = 150 * 65536;
   localparam int LIGHT_Z_Q16 = 0;

   localparam int ONE_Q14    = 16384;
   localparam int ROUND_HALF = 8192;
   localparam int POW_SAT    = 16777216;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 15;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIFFUSE_RED    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIFFUSE_GREEN  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIFFUSE_BLUE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPECULAR_RED   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPECULAR_GREEN = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPECULAR_BLUE  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHININESS      = 3'd6;

endpackage

FILE: rtl/blinn_phong_vertex_lighting.sv
// Throughput: one vertex per cycle; the whole pipeline holds while a result waits.
// Depth is set by the exponent chain (one multiply stage per power step) and two
// 53-stage normalizers in series (pipelined square root and quotient, one bit a stage).
// Reset (synchronous) clears all valid bits and loads the material register defaults.
module blinn_phong_vertex_lighting #(
   parameter int MAX_SHININESS = 255,
   parameter int POS_WIDTH     = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [15:0]                            req_vertex_index,
   input  logic signed [POS_WIDTH-1:0]            req_view_pos_x,
   input  logic signed [POS_WIDTH-1:0]            req_view_pos_y,
   input  logic signed [POS_WIDTH-1:0]            req_view_pos_z,
   input  logic signed [15:0]                     req_normal_x,
   input  logic signed [15:0]                     req_normal_y,
   input  logic signed [15:0]                     req_normal_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [15:0]                            rsp_vertex_tag,
   output logic signed [15:0]                     rsp_colour_red,
   output logic signed [15:0]                     rsp_colour_green,
   output logic signed [15:0]                     rsp_colour_blue,
   input  logic                                   csr_write_enable,
   input  logic [bpvl_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bpvl_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import bpvl_pkg::*;

   localparam int LW   = ((POS_WIDTH > 25) ? POS_WIDTH : 25) + 1;
   localparam int VW   = POS_WIDTH + 1;
   localparam int S_IN = 1;
   localparam int S_L  = S_IN + NORM_LAT;
   localparam int S_H  = S_L + 1;
   localparam int S_N2 = S_H + NORM_LAT;
   localparam int S_DP = S_N2 + 1;
   localparam int S_DS = S_DP + 1;
   localparam int S_PW = S_DS + MAX_SHININESS;
   localparam int S_CP = S_PW + 1;
   localparam int LAT  = S_CP + 1;
   localparam int EW   = ($clog2(MAX_SHININESS + 1) > 8) ? $clog2(MAX_SHININESS + 1) : 8;

   // material registers
   logic [14:0] kd_ff [3];
   logic [14:0] ks_ff [3];
   logic [7:0]  shin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            kd_ff[c] <= 15'(ONE_Q14);
            ks_ff[c] <= '0;
         end
         shin_ff <= 8'd16;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DIFFUSE_RED:    kd_ff[0] <= csr_wdata;
            CSR_DIFFUSE_GREEN:  kd_ff[1] <= csr_wdata;
            CSR_DIFFUSE_BLUE:   kd_ff[2] <= csr_wdata;
            CSR_SPECULAR_RED:   ks_ff[0] <= csr_wdata;
            CSR_SPECULAR_GREEN: ks_ff[1] <= csr_wdata;
            CSR_SPECULAR_BLUE:  ks_ff[2] <= csr_wdata;
            CSR_SHININESS:      shin_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic [EW-1:0] e_lim;
   assign e_lim = (EW'(shin_ff) > EW'(MAX_SHININESS)) ? EW'(MAX_SHININESS) : EW'(shin_ff);

   // pipeline control: one global advance
   logic           en;
   logic [LAT:1]   vld_ff;

   assign en        = !vld_ff[LAT] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-1:1], req_valid};
      end
   end

   // light and view vectors
   logic signed [LW-1:0] lv_ff [3];
   logic signed [VW-1:0] vv_ff [3];
   logic [15:0]          tag_ff [S_IN:LAT];
   q14_type              nrm_ff [S_IN:S_N2][3];

   always_ff @(posedge clock) begin
      if (en) begin
         lv_ff[0] <= LW'(LIGHT_X_Q16) - LW'(req_view_pos_x);
         lv_ff[1] <= LW'(LIGHT_Y_Q16) - LW'(req_view_pos_y);
         lv_ff[2] <= LW'(LIGHT_Z_Q16) - LW'(req_view_pos_z);
         vv_ff[0] <= -VW'(req_view_pos_x);
         vv_ff[1] <= -VW'(req_view_pos_y);
         vv_ff[2] <= -VW'(req_view_pos_z);
         tag_ff[S_IN]    <= req_vertex_index;
         nrm_ff[S_IN][0] <= req_normal_x;
         nrm_ff[S_IN][1] <= req_normal_y;
         nrm_ff[S_IN][2] <= req_normal_z;
         for (int k = S_IN + 1; k <= LAT - 1; k++) tag_ff[k] <= tag_ff[k-1];
         for (int k = S_IN + 1; k <= S_N2; k++) nrm_ff[k] <= nrm_ff[k-1];
      end
   end

   q14_type lu_w [3];
   q14_type vu_w [3];
   q14_type hu_w [3];

   bpvl_norm #(.W(LW)) u_norm_light (
      .clock    (clock),
      .en       (en),
      .src_vec  (lv_ff),
      .unit_vec (lu_w)
   );

   bpvl_norm #(.W(VW)) u_norm_view (
      .clock    (clock),
      .en       (en),
      .src_vec  (vv_ff),
      .unit_vec (vu_w)
   );

   // half vector
   logic signed [16:0] hv_ff [3];
   q14_type            lud_ff [S_H:S_N2][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) hv_ff[c] <= 17'(lu_w[c]) + 17'(vu_w[c]);
         lud_ff[S_H] <= lu_w;
         for (int k = S_H + 1; k <= S_N2; k++) lud_ff[k] <= lud_ff[k-1];
      end
   end

   bpvl_norm #(.W(17)) u_norm_half (
      .clock    (clock),
      .en       (en),
      .src_vec  (hv_ff),
      .unit_vec (hu_w)
   );

   // dot products
   logic signed [31:0] pl_ff [3];
   logic signed [31:0] ph_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            pl_ff[c] <= 32'(lud_ff[S_N2][c]) * 32'(nrm_ff[S_N2][c]);
            ph_ff[c] <= 32'(hu_w[c]) * 32'(nrm_ff[S_N2][c]);
         end
      end
   end

   logic signed [33:0] dsl_in, dsh_in;
   logic signed [17:0] drl_in, drh_in, d_in, s_in;

   always_comb begin
      dsl_in = 34'(pl_ff[0]) + 34'(pl_ff[1]) + 34'(pl_ff[2]) + 34'(ROUND_HALF);
      dsh_in = 34'(ph_ff[0]) + 34'(ph_ff[1]) + 34'(ph_ff[2]) + 34'(ROUND_HALF);
      drl_in = 18'(dsl_in >>> 14);
      drh_in = 18'(dsh_in >>> 14);
      d_in   = (drl_in < 0) ? '0 : drl_in;
      s_in   = (d_in == 0) ? '0 : drh_in;
   end

   // power chain: one rounded multiply per exponent step
   logic signed [25:0] pw_acc_ff [S_DS:S_PW];
   logic signed [17:0] pw_d_ff   [S_DS:S_PW];
   logic signed [17:0] pw_s_ff   [S_DS:S_PW-1];

   always_ff @(posedge clock) begin
      if (en) begin
         pw_acc_ff[S_DS] <= 26'(ONE_Q14);
         pw_d_ff[S_DS]   <= d_in;
         pw_s_ff[S_DS]   <= s_in;
      end
   end

   for (genvar k = 1; k <= MAX_SHININESS; k++) begin : g_pow
      localparam int ST = S_DS + k;
      logic signed [43:0] prod;
      logic signed [43:0] rnd;
      logic signed [29:0] q;
      logic signed [25:0] nxt;

      always_comb begin
         prod = 44'(pw_acc_ff[ST-1]) * 44'(pw_s_ff[ST-1]);
         rnd  = (prod + 44'(ROUND_HALF)) >>> 14;
         q    = 30'(rnd);
         if (q > 30'(POW_SAT)) begin
            nxt = 26'(POW_SAT);
         end else if (q < -30'(POW_SAT)) begin
            nxt = -26'(POW_SAT);
         end else begin
            nxt = 26'(q);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pw_acc_ff[ST] <= (EW'(k - 1) < e_lim) ? nxt : pw_acc_ff[ST-1];
            pw_d_ff[ST]   <= pw_d_ff[ST-1];
         end
      end

      if (k < MAX_SHININESS) begin : g_s
         always_ff @(posedge clock) begin
            if (en) pw_s_ff[ST] <= pw_s_ff[ST-1];
         end
      end
   end

   // colour mix
   logic signed [33:0] cd_ff [3];
   logic signed [41:0] cs_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            cd_ff[c] <= 34'(pw_d_ff[S_PW]) * 34'(signed'({1'b0, kd_ff[c]}));
            cs_ff[c] <= 42'(pw_acc_ff[S_PW]) * 42'(signed'({1'b0, ks_ff[c]}));
         end
      end
   end

   logic signed [42:0] csum_in [3];
   logic signed [28:0] cr_in   [3];
   q14_type            col_in  [3];
   q14_type            col_ff  [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         csum_in[c] = 43'(cd_ff[c]) + 43'(cs_ff[c]) + 43'(ROUND_HALF);
         cr_in[c]   = 29'(csum_in[c] >>> 14);
         if (cr_in[c] > 29'(ONE_Q14)) begin
            col_in[c] = 16'(ONE_Q14);
         end else if (cr_in[c] < -29'sd32768) begin
            col_in[c] = -16'sd32768;
         end else begin
            col_in[c] = 16'(cr_in[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff         <= col_in;
         tag_ff[LAT]    <= tag_ff[LAT-1];
      end
   end

   assign rsp_vertex_tag   = tag_ff[LAT];
   assign rsp_colour_red   = col_ff[0];
   assign rsp_colour_green = col_ff[1];
   assign rsp_colour_blue  = col_ff[2];

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("valid bits moved during a stall");

   a_valid_travels: assert property (@(posedge clock) disable iff (reset)
      en |=> (vld_ff[LAT] == $past(vld_ff[LAT-1])))
      else $error("beat lost or invented at the output stage");

   a_dot_terms: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_DS] |-> (pw_d_ff[S_DS] >= 0) && (pw_d_ff[S_DS] != 0 || pw_s_ff[S_DS] == 0))
      else $error("diffuse negative or specular not gated");

   a_colour_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (col_ff[0] <= 16'sd16384) && (col_ff[1] <= 16'sd16384) &&
                    (col_ff[2] <= 16'sd16384))
      else $error("colour above 1.0");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

FILE: rtl/bpvl_norm.sv
module bpvl_norm #(
   parameter int W = 33
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W-1:0] src_vec [3],
   output bpvl_pkg::q14_type   unit_vec [3]
);
   import bpvl_pkg::*;

   localparam int BW = $clog2(W + 1);
   localparam int RB = 31;
   localparam int QB = 15;

   // magnitude and largest component
   logic [W-1:0] mag_in [3];
   logic [W-1:0] max_in;
   logic [W-1:0] mag1_ff [3];
   logic [2:0]   neg1_ff;
   logic [W-1:0] max1_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag_in[c] = src_vec[c][W-1] ? W'(-src_vec[c]) : W'(src_vec[c]);
      end
      max_in = mag_in[0];
      if (mag_in[1] > max_in) max_in = mag_in[1];
      if (mag_in[2] > max_in) max_in = mag_in[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            mag1_ff[c] <= mag_in[c];
            neg1_ff[c] <= src_vec[c][W-1];
         end
         max1_ff <= max_in;
      end
   end

   // bit length of the largest magnitude
   logic [BW-1:0] blen_in;
   logic [BW-1:0] blen2_ff;
   logic [W-1:0]  mag2_ff [3];
   logic [2:0]    neg2_ff;

   always_comb begin
      blen_in = '0;
      for (int b = 0; b < W; b++) begin
         if (max1_ff[b]) blen_in = BW'(b + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         blen2_ff <= blen_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
      end
   end

   // align so the largest lands in [2^29, 2^30)
   logic [6:0]  bl7;
   logic [63:0] wide_in [3];
   logic [29:0] al3_ff [3];
   logic [2:0]  neg3_ff;
   logic        zero3_ff;

   always_comb begin
      bl7 = 7'(blen2_ff);
      for (int c = 0; c < 3; c++) begin
         if (bl7 > 7'd30) begin
            wide_in[c] = 64'(mag2_ff[c]) >> (bl7 - 7'd30);
         end else begin
            wide_in[c] = 64'(mag2_ff[c]) << (7'd30 - bl7);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) al3_ff[c] <= wide_in[c][29:0];
         neg3_ff  <= neg2_ff;
         zero3_ff <= (blen2_ff == '0);
      end
   end

   // squares, then their sum
   logic [59:0] sq4_ff [3];
   logic [29:0] al4_ff [3];
   logic [2:0]  neg4_ff;
   logic        zero4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) sq4_ff[c] <= 60'(al3_ff[c]) * 60'(al3_ff[c]);
         al4_ff   <= al3_ff;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;
      end
   end

   logic [61:0]   rem_ff  [RB+1];
   logic [RB-1:0] root_ff [RB+1];
   logic [29:0]   sal_ff  [RB+1][3];
   logic [2:0]    sneg_ff [RB+1];
   logic          szero_ff [RB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]   <= 62'(sq4_ff[0]) + 62'(sq4_ff[1]) + 62'(sq4_ff[2]);
         root_ff[0]  <= '0;
         sal_ff[0]   <= al4_ff;
         sneg_ff[0]  <= neg4_ff;
         szero_ff[0] <= zero4_ff;
      end
   end

   // integer square root, one root bit per stage, msb first
   for (genvar g = 1; g <= RB; g++) begin : g_sqrt
      localparam int I = RB - g;
      logic [61:0] trial;
      assign trial = (62'(root_ff[g-1]) << (I + 1)) | (62'(1) << (2 * I));

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[g-1] >= trial) begin
               rem_ff[g]  <= rem_ff[g-1] - trial;
               root_ff[g] <= root_ff[g-1] | (RB'(1) << I);
            end else begin
               rem_ff[g]  <= rem_ff[g-1];
               root_ff[g] <= root_ff[g-1];
            end
            sal_ff[g]   <= sal_ff[g-1];
            sneg_ff[g]  <= sneg_ff[g-1];
            szero_ff[g] <= szero_ff[g-1];
         end
      end
   end

   // rounded division of each component by the length
   logic [45:0]   drem_ff [QB+1][3];
   logic [QB-1:0] dq_ff   [QB+1][3];
   logic [RB-1:0] dlen_ff [QB+1];
   logic [2:0]    dneg_ff [QB+1];
   logic          dzero_ff [QB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            drem_ff[0][c] <= (46'(sal_ff[RB][c]) << 14) + 46'(root_ff[RB] >> 1);
            dq_ff[0][c]   <= '0;
         end
         dlen_ff[0]  <= root_ff[RB];
         dneg_ff[0]  <= sneg_ff[RB];
         dzero_ff[0] <= szero_ff[RB];
      end
   end

   for (genvar g = 1; g <= QB; g++) begin : g_div
      localparam int I = QB - g;
      logic [45:0] dvs;
      assign dvs = 46'(dlen_ff[g-1]) << I;

      always_ff @(posedge clock) begin
         if (en) begin
            for (int c = 0; c < 3; c++) begin
               if (drem_ff[g-1][c] >= dvs) begin
                  drem_ff[g][c] <= drem_ff[g-1][c] - dvs;
                  dq_ff[g][c]   <= dq_ff[g-1][c] | (QB'(1) << I);
               end else begin
                  drem_ff[g][c] <= drem_ff[g-1][c];
                  dq_ff[g][c]   <= dq_ff[g-1][c];
               end
            end
            dlen_ff[g]  <= dlen_ff[g-1];
            dneg_ff[g]  <= dneg_ff[g-1];
            dzero_ff[g] <= dzero_ff[g-1];
         end
      end
   end

   q14_type unit_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            if (dzero_ff[QB]) begin
               unit_ff[c] <= '0;
            end else if (dneg_ff[QB][c]) begin
               unit_ff[c] <= -16'(dq_ff[QB][c]);
            end else begin
               unit_ff[c] <= 16'(dq_ff[QB][c]);
            end
         end
      end
   end

   assign unit_vec = unit_ff;

endmodule
